// File: src/bitmap_id_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap identifier allocator
// Concurrent checks that vanish when the SYNTHESIS macro is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ID_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_ID_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define BIA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bitmap_id_allocator: check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BIA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bitmap_id_allocator: check failed");

`else

`define BIA_ASSERT_IMP(label, ante, cons)
`define BIA_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: src/bia_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap identifier allocator package
// Command and status codes, transaction payload types and shared constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bia_pkg;

  // Default map size in bits.
  localparam int MAX_BITS_DEF = 1024;

  // The map is stored as words of 2**WS bits.
  localparam int WS        = 6;
  localparam int WORD_BITS = 1 << WS;

  // Reset value of the size limit register.
  localparam logic [10:0] SIZE_LIMIT_RST = 11'd1024;

  // Register index, taken from paddr[2].
  localparam logic REG_SIZE_LIMIT = 1'b0;

  // Command codes.
  localparam logic [2:0] CMD_SET    = 3'd0;
  localparam logic [2:0] CMD_CLEAR  = 3'd1;
  localparam logic [2:0] CMD_TEST   = 3'd2;
  localparam logic [2:0] CMD_FIND   = 3'd3;
  localparam logic [2:0] CMD_RESIZE = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_NOFREE = 2'd2;

  // Command transaction.
  typedef struct packed {
    logic [2:0]  command;
    logic [10:0] index;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic [1:0]  status;
    logic        bit_value;
    logic [10:0] free_index;
  } out_t;

endpackage

`default_nettype wire

// File: src/bia_ram.sv
// ----------------------------------------------------------------------------
// Bitmap word memory
// Simple dual-port RAM: one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bia_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/bitmap_id_allocator_top.sv
// ----------------------------------------------------------------------------
// Bitmap identifier allocator
// Set, clear, test, find-first-free and resize over a map stored in 64-bit words.
// ----------------------------------------------------------------------------
// Out-of-range, unknown and empty-span commands answer in the cycle after accept;
//   set, clear and test go through a word read, then a read-modify-write.
// Find free scans the 64-bit words in order, each through read, mask and priority pick states.
// Resize clears each word from the new end of the map upward, reading a partial word first.
// One command at a time; the next is accepted at the edge taking the result.
// After reset a clearing pass writes ceil(MAX_BITS/64) words with busy high; no stall.
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_id_allocator_top_defines.svh"

module bitmap_id_allocator_top #(
  parameter int MAX_BITS = bia_pkg::MAX_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  bia_pkg::in_t  request,
  output logic          busy,
  output logic          done,
  output bia_pkg::out_t result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int WS    = bia_pkg::WS;
  localparam int WB    = bia_pkg::WORD_BITS;
  localparam int WORDS = (MAX_BITS + WB - 1) / WB;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int NW    = (AW + WS + 1 > 11) ? AW + WS + 1 : 11;

  localparam logic [NW-1:0]    SIZE_RST  = NW'(MAX_BITS);
  localparam logic [NW-1:0]    CAP       = NW'((MAX_BITS / 8) * 8);
  localparam logic [AW-1:0]    LAST_WORD = AW'(WORDS - 1);
  localparam logic [NW-WS-1:0] WORDS_N   = (NW-WS)'(WORDS);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_BIT_RD,
    S_BIT_EXEC,
    S_FIND_RD,
    S_FIND_DATA,
    S_FIND_EVAL,
    S_RSZ_RD,
    S_RSZ_FIRST,
    S_RSZ_ZERO
  } state_t;

  state_t          state;
  logic [10:0]     size_limit;
  logic [NW-1:0]   cur_size;
  logic [NW-1:0]   nval;
  logic [2:0]      op;
  logic [AW-1:0]   word_addr;
  logic [WS-1:0]   bit_pos;
  logic [WS:0]     scan_valid;
  logic [WB-1:0]   scan_word;
  logic [7:0]      byte_flags;

  logic            ram_we;
  logic [WB-1:0]   ram_wdata;
  logic [WB-1:0]   ram_rdata;

  logic [NW-1:0]    n_ext;
  logic [NW-1:0]    bit0;
  logic             index_ok;
  logic [NW-1:0]    lim_ext;
  logic [NW-1:0]    eff_limit;
  logic [NW-1:0]    span;
  logic [NW-WS-1:0] start_word;
  logic [NW-1:0]    word_base;
  logic [NW-1:0]    rem;
  logic [WS:0]      valid_next;
  logic [AW:0]      wa_inc;
  logic [NW-1:0]    next_base;
  logic [WB-1:0]    avail;
  logic [7:0]       flags;
  logic [2:0]       byte_sel;
  logic [7:0]       byte_val;
  logic [2:0]       bit_in;
  logic [NW-1:0]    free_pos;
  logic [WB-1:0]    bit_word;
  logic [WB-1:0]    keep_mask;

  // Configuration port: always ready, one register at byte address zero.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bia_pkg::REG_SIZE_LIMIT) ? {21'd0, size_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= bia_pkg::SIZE_LIMIT_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == bia_pkg::REG_SIZE_LIMIT)) begin
      size_limit <= pwdata[10:0];
    end
  end

  // Command decode helpers.
  always_comb begin
    n_ext      = NW'(request.index);
    bit0       = n_ext - NW'(1);
    index_ok   = (request.index != 11'd0) && (n_ext <= cur_size);
    lim_ext    = NW'({size_limit[10:3], 3'b000});
    eff_limit  = (lim_ext > CAP) ? CAP : lim_ext;
    span       = {cur_size[NW-1:3], 3'b000};
    start_word = n_ext[NW-1:WS];
  end

  // Scan helpers: how many bits of the current word lie inside the span,
  // and where the next word starts.
  always_comb begin
    word_base  = NW'({word_addr, {WS{1'b0}}});
    rem        = nval - word_base;
    valid_next = (rem >= NW'(WB)) ? (WS+1)'(WB) : rem[WS:0];
    wa_inc     = {1'b0, word_addr} + (AW+1)'(1);
    next_base  = NW'({wa_inc, {WS{1'b0}}});
  end

  // Free bits of the word just read, restricted to the span, and per-byte flags.
  always_comb begin
    for (int j = 0; j < WB; j++) begin
      avail[j] = ~ram_rdata[j] && ((WS+1)'(j) < scan_valid);
    end
    for (int k = 0; k < 8; k++) begin
      flags[k] = |avail[8*k +: 8];
    end
  end

  // Priority pick: lowest flagged byte, then lowest free bit inside it.
  always_comb begin
    byte_sel = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (byte_flags[k]) begin
        byte_sel = 3'(k);
      end
    end
    byte_val = scan_word[{byte_sel, 3'b000} +: 8];
    bit_in   = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (byte_val[j]) begin
        bit_in = 3'(j);
      end
    end
    free_pos = NW'({word_addr, byte_sel, bit_in}) + NW'(1);
  end

  // Write data for single-bit updates and for the partial word of a resize.
  always_comb begin
    bit_word          = ram_rdata;
    bit_word[bit_pos] = (op == bia_pkg::CMD_SET);
    for (int j = 0; j < WB; j++) begin
      keep_mask[j] = (WS'(j) < nval[WS-1:0]);
    end
  end

  // Memory write control.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    unique case (state)
      S_CLEAR, S_RSZ_ZERO: begin
        ram_we = 1'b1;
      end
      S_BIT_EXEC: begin
        ram_we    = (op != bia_pkg::CMD_TEST);
        ram_wdata = bit_word;
      end
      S_RSZ_FIRST: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & keep_mask;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  bia_ram #(
    .DEPTH (WORDS),
    .AW    (AW),
    .WIDTH (WB)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_addr),
    .wdata (ram_wdata),
    .raddr (word_addr),
    .rdata (ram_rdata)
  );

  // Sequencer with registered busy and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      busy      <= 1'b1;
      done      <= 1'b0;
      word_addr <= '0;
      cur_size  <= SIZE_RST;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (word_addr == LAST_WORD) begin
            word_addr <= '0;
            busy      <= 1'b0;
            state     <= S_IDLE;
          end else begin
            word_addr <= word_addr + AW'(1);
          end
        end

        S_IDLE: begin
          if (start) begin
            op                <= request.command;
            result.bit_value  <= 1'b0;
            result.free_index <= 11'd0;
            unique case (request.command)
              bia_pkg::CMD_SET, bia_pkg::CMD_CLEAR, bia_pkg::CMD_TEST: begin
                if (index_ok) begin
                  word_addr <= bit0[AW+WS-1:WS];
                  bit_pos   <= bit0[WS-1:0];
                  busy      <= 1'b1;
                  state     <= S_BIT_RD;
                end else begin
                  done          <= 1'b1;
                  result.status <= bia_pkg::ST_RANGE;
                end
              end
              bia_pkg::CMD_FIND: begin
                if (span == NW'(0)) begin
                  done          <= 1'b1;
                  result.status <= bia_pkg::ST_NOFREE;
                end else begin
                  nval      <= span;
                  word_addr <= '0;
                  busy      <= 1'b1;
                  state     <= S_FIND_RD;
                end
              end
              bia_pkg::CMD_RESIZE: begin
                if (n_ext > eff_limit) begin
                  done          <= 1'b1;
                  result.status <= bia_pkg::ST_RANGE;
                end else begin
                  cur_size <= n_ext;
                  nval     <= n_ext;
                  if (start_word >= WORDS_N) begin
                    done          <= 1'b1;
                    result.status <= bia_pkg::ST_OK;
                  end else begin
                    word_addr <= start_word[AW-1:0];
                    busy      <= 1'b1;
                    state     <= (n_ext[WS-1:0] != WS'(0)) ? S_RSZ_RD : S_RSZ_ZERO;
                  end
                end
              end
              default: begin
                done          <= 1'b1;
                result.status <= bia_pkg::ST_RANGE;
              end
            endcase
          end
        end

        S_BIT_RD: begin
          state <= S_BIT_EXEC;
        end

        S_BIT_EXEC: begin
          done             <= 1'b1;
          result.status    <= bia_pkg::ST_OK;
          result.bit_value <= (op == bia_pkg::CMD_TEST) && ram_rdata[bit_pos];
          busy             <= 1'b0;
          state            <= S_IDLE;
        end

        S_FIND_RD: begin
          scan_valid <= valid_next;
          state      <= S_FIND_DATA;
        end

        S_FIND_DATA: begin
          scan_word  <= avail;
          byte_flags <= flags;
          state      <= S_FIND_EVAL;
        end

        S_FIND_EVAL: begin
          if (|byte_flags) begin
            done              <= 1'b1;
            result.status     <= bia_pkg::ST_OK;
            result.free_index <= free_pos[10:0];
            busy              <= 1'b0;
            state             <= S_IDLE;
          end else if (next_base >= nval) begin
            done          <= 1'b1;
            result.status <= bia_pkg::ST_NOFREE;
            busy          <= 1'b0;
            state         <= S_IDLE;
          end else begin
            word_addr <= wa_inc[AW-1:0];
            state     <= S_FIND_RD;
          end
        end

        S_RSZ_RD: begin
          state <= S_RSZ_FIRST;
        end

        S_RSZ_FIRST, S_RSZ_ZERO: begin
          if (word_addr == LAST_WORD) begin
            done          <= 1'b1;
            result.status <= bia_pkg::ST_OK;
            busy          <= 1'b0;
            state         <= S_IDLE;
          end else begin
            word_addr <= word_addr + AW'(1);
            state     <= S_RSZ_ZERO;
          end
        end

        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted command either answers at once or keeps the block busy.
  `BIA_ASSERT_NXT(a_accept_progress, start && !busy, done || busy)
  // Only defined status codes are reported.
  `BIA_ASSERT_IMP(a_status_code, done, result.status <= bia_pkg::ST_NOFREE)
  // A free index is reported only with an ok status.
  `BIA_ASSERT_IMP(a_free_ok, done && (result.free_index != 11'd0), result.status == bia_pkg::ST_OK)
  // A set bit value is reported only with an ok status.
  `BIA_ASSERT_IMP(a_bit_ok, done && result.bit_value, result.status == bia_pkg::ST_OK)

endmodule

`default_nettype wire
